### hdl/fubd_pkg.sv
// ----------------------------------------------------------------------------
// fubd_pkg: shared types and constants of the form body decoder
// Result kinds, the command word passed from front to back, queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package fubd_pkg;

   // result kinds
   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_NAME_END = 2'd1;
   localparam logic [1:0] KIND_PAIR_END = 2'd2;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one result item
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } res_type;

   // work for the back end caused by one transaction: up to three bytes for
   // the utf-8 decoder, then an optional piece close with its markers
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      nbytes;
      logic            close;
      logic            eon;
      logic            eop;
   } cmd_type;

endpackage

`default_nettype wire

### hdl/fubd_if.sv
// ----------------------------------------------------------------------------
// fubd_if: handshake channels of the form body decoder
// Request channel (raw body bytes) and response channel (decoded results).
// ----------------------------------------------------------------------------
`default_nettype none

interface fubd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       is_end;

   modport source (output valid, output body_byte, output is_end, input ready);
   modport sink   (input valid, input body_byte, input is_end, output ready);
endinterface

interface fubd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output kind, output out_byte, output last, input ready);
   modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

`default_nettype wire

### hdl/form_urlencoded_body_decoder.sv
// ----------------------------------------------------------------------------
// form_urlencoded_body_decoder: streaming form body decoder
// Splits a urlencoded body into name/value pieces, undoes '+' and %XX
// escapes and passes the bytes through a utf-8 decoder with replacement.
// ----------------------------------------------------------------------------
//
//  channel   dir  transaction contents
//  req_if    in   body_byte, is_end (end of body, flushes the open pair)
//  rsp_if    out  kind (data / end of name / end of pair), out_byte, last
//
//  a request transaction can be taken every cycle while the four-entry
//  command queue has room; the front classifies it in the cycle it arrives
//  the back end gives one result per cycle while rsp_if is ready; a
//  transaction gives up to eight results (for escape flushes), and a final
//  byte that only opens or extends a utf-8 sequence gives none; a transaction
//  that only holds a '%' or a digit, or an empty segment, never reaches it
//  reset is synchronous and empties the queue and the output register
//  a stalled rsp_if fills the queue and then drops req_if.ready
//
`default_nettype none

module form_urlencoded_body_decoder (
   input  wire logic clock,
   input  wire logic reset,
   fubd_req_if.sink   req_if,
   fubd_rsp_if.source rsp_if
);

   // front to queue
   fubd_pkg::cmd_type push_cmd;
   logic              push;
   logic              q_full;

   // queue to back
   fubd_pkg::cmd_type head_cmd;
   logic              head_valid;
   logic              pop;

   // segment, name/value and escape tracking
   fubd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .q_full   (q_full),
      .push_cmd (push_cmd),
      .push     (push)
   );

   // decouples byte intake from result delivery
   fubd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .full       (q_full)
   );

   // utf-8 decoding and sequencing at one result per cycle while rsp_if is ready
   fubd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

   // end of pair always closes the results of its transaction
   a_pair_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.kind == fubd_pkg::KIND_PAIR_END) |-> rsp_if.last)
      else $error("end of pair not flagged last");

   // no result appears without queued work
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!head_valid && !rsp_if.valid) |=> !rsp_if.valid)
      else $error("result produced with empty queue");

   // markers carry a zero byte
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.kind != fubd_pkg::KIND_DATA) |-> rsp_if.out_byte == 8'h00)
      else $error("marker with non-zero byte");

   // nothing is offered straight after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

### hdl/fubd_front.sv
// ----------------------------------------------------------------------------
// fubd_front: segment and escape classifier
// Tracks name/value, open segment and pending percent escape; turns each
// accepted body byte that yields work into a command for the utf-8 back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fubd_front (
   input  wire logic          clock,
   input  wire logic          reset,
   fubd_req_if.sink           req_if,
   input  wire logic          q_full,
   output fubd_pkg::cmd_type  push_cmd,
   output logic               push
);

   localparam logic [1:0] ESC_NONE  = 2'd0;
   localparam logic [1:0] ESC_PCT   = 2'd1;
   localparam logic [1:0] ESC_DIGIT = 2'd2;

   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_SPACE = 8'h20;

   function automatic logic hex_ok(input logic [7:0] c);
      hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      hex_val = c[3:0] + (c[6] ? 4'd9 : 4'd0);
   endfunction

   logic       in_value_ff, in_value_in;
   logic       seg_open_ff, seg_open_in;
   logic [1:0] esc_ff, esc_in;
   logic [7:0] held_ff, held_in;

   logic       accept;
   logic       plain;
   logic [1:0] k;
   logic [7:0] b;
   fubd_pkg::cmd_type cmd;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && !q_full;
   assign b            = req_if.body_byte;

   always_comb begin
      cmd          = '0;
      in_value_in  = in_value_ff;
      seg_open_in  = seg_open_ff;
      esc_in       = esc_ff;
      held_in      = held_ff;
      plain        = 1'b0;
      k            = 2'd0;
      if (accept) begin
         if (req_if.is_end || b == CH_AMP) begin
            if (seg_open_ff) begin
               // pending escape goes out verbatim, then the segment closes
               cmd.bytes[0] = CH_PCT;
               cmd.bytes[1] = held_ff;
               cmd.nbytes   = esc_ff;
               cmd.close    = 1'b1;
               cmd.eon      = !in_value_ff;
               cmd.eop      = 1'b1;
               in_value_in  = 1'b0;
               seg_open_in  = 1'b0;
               esc_in       = ESC_NONE;
            end
         end else begin
            seg_open_in = 1'b1;
            if (b == CH_EQ && !in_value_ff) begin
               cmd.bytes[0] = CH_PCT;
               cmd.bytes[1] = held_ff;
               cmd.nbytes   = esc_ff;
               cmd.close    = 1'b1;
               cmd.eon      = 1'b1;
               in_value_in  = 1'b1;
               esc_in       = ESC_NONE;
            end else begin
               unique case (esc_ff)
                  ESC_NONE: begin
                     plain = 1'b1;
                  end
                  ESC_PCT: begin
                     if (hex_ok(b)) begin
                        held_in = b;
                        esc_in  = ESC_DIGIT;
                     end else begin
                        cmd.bytes[0] = CH_PCT;
                        k            = 2'd1;
                        plain        = 1'b1;
                     end
                  end
                  ESC_DIGIT: begin
                     if (hex_ok(b)) begin
                        cmd.bytes[0] = {hex_val(held_ff), hex_val(b)};
                        cmd.nbytes   = 2'd1;
                        esc_in       = ESC_NONE;
                     end else begin
                        cmd.bytes[0] = CH_PCT;
                        cmd.bytes[1] = held_ff;
                        k            = 2'd2;
                        plain        = 1'b1;
                     end
                  end
                  default: begin
                     esc_in = ESC_NONE;
                  end
               endcase
               // byte taken as ordinary piece data after any flushed prefix
               if (plain) begin
                  if (b == CH_PCT) begin
                     cmd.nbytes = k;
                     esc_in     = ESC_PCT;
                  end else begin
                     cmd.bytes[k] = (b == CH_PLUS) ? CH_SPACE : b;
                     cmd.nbytes   = k + 2'd1;
                     esc_in       = ESC_NONE;
                  end
               end
            end
         end
      end
   end

   assign push_cmd = cmd;
   assign push     = accept && (cmd.nbytes != 2'd0 || cmd.close);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_value_ff <= 1'b0;
         seg_open_ff <= 1'b0;
         esc_ff      <= ESC_NONE;
      end else begin
         in_value_ff <= in_value_in;
         seg_open_ff <= seg_open_in;
         esc_ff      <= esc_in;
      end
      held_ff <= held_in;
   end

endmodule

`default_nettype wire

### hdl/fubd_queue.sv
// ----------------------------------------------------------------------------
// fubd_queue: command queue between front and back
// Small fifo so that the front keeps taking bytes while the back is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module fubd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire fubd_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output fubd_pkg::cmd_type      head_cmd,
   output logic                   head_valid,
   output logic                   full
);

   fubd_pkg::cmd_type mem_ff [fubd_pkg::QUEUE_DEPTH];

   logic [fubd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fubd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fubd_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == fubd_pkg::QCNT_W'(fubd_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### hdl/fubd_back.sv
// ----------------------------------------------------------------------------
// fubd_back: utf-8 decoder and result sequencer
// Walks the elements of the head command, one result per cycle while the
// output register is free, and holds the result in that output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fubd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire fubd_pkg::cmd_type head_cmd,
   output logic                   pop,
   fubd_rsp_if.source             rsp_if
);

   typedef struct packed {
      logic [1:0]  needed;
      logic [20:0] cp;
      logic [7:0]  lower;
      logic [7:0]  upper;
   } u8_state_type;

   typedef struct packed {
      fubd_pkg::res_type [5:0] outs;
      logic [2:0]              cnt;
      u8_state_type            nstate;
   } exp_type;

   localparam u8_state_type U8_IDLE = '{needed: 2'd0, cp: 21'd0,
                                        lower: 8'h80, upper: 8'hbf};

   localparam logic [7:0] REPL_0 = 8'hef;
   localparam logic [7:0] REPL_1 = 8'hbf;
   localparam logic [7:0] REPL_2 = 8'hbd;

   function automatic fubd_pkg::res_type data_res(input logic [7:0] d);
      data_res = '{kind: fubd_pkg::KIND_DATA, data: d};
   endfunction

   function automatic logic [7:0] pick_byte(input logic [2:0][7:0] bytes,
                                            input logic [1:0] idx);
      case (idx)
         2'd0:    pick_byte = bytes[0];
         2'd1:    pick_byte = bytes[1];
         2'd2:    pick_byte = bytes[2];
         default: pick_byte = 8'h00;
      endcase
   endfunction

   // one byte through the decoder: results and state after it
   function automatic exp_type byte_expand(input u8_state_type st, input logic [7:0] b);
      exp_type     r;
      logic        lead;
      logic [2:0]  base;
      logic [20:0] cp;
      r      = '0;
      r.nstate = st;
      lead   = 1'b0;
      base   = 3'd0;
      cp     = '0;
      if (st.needed == 2'd0) begin
         lead = 1'b1;
      end else if (b < st.lower || b > st.upper) begin
         // bad continuation: replacement, then the byte starts over as a lead
         r.outs[0] = data_res(REPL_0);
         r.outs[1] = data_res(REPL_1);
         r.outs[2] = data_res(REPL_2);
         r.cnt     = 3'd3;
         r.nstate  = U8_IDLE;
         lead      = 1'b1;
         base      = 3'd3;
      end else begin
         cp              = {st.cp[14:0], b[5:0]};
         r.nstate.needed = st.needed - 2'd1;
         r.nstate.cp     = cp;
         r.nstate.lower  = 8'h80;
         r.nstate.upper  = 8'hbf;
         if (st.needed == 2'd1) begin
            r.nstate.cp = '0;
            if (cp <= 21'h7f) begin
               r.outs[0] = data_res(cp[7:0]);
               r.cnt     = 3'd1;
            end else if (cp <= 21'h7ff) begin
               r.outs[0] = data_res({3'b110, cp[10:6]});
               r.outs[1] = data_res({2'b10, cp[5:0]});
               r.cnt     = 3'd2;
            end else if (cp <= 21'hffff) begin
               r.outs[0] = data_res({4'b1110, cp[15:12]});
               r.outs[1] = data_res({2'b10, cp[11:6]});
               r.outs[2] = data_res({2'b10, cp[5:0]});
               r.cnt     = 3'd3;
            end else begin
               r.outs[0] = data_res({5'b11110, cp[20:18]});
               r.outs[1] = data_res({2'b10, cp[17:12]});
               r.outs[2] = data_res({2'b10, cp[11:6]});
               r.outs[3] = data_res({2'b10, cp[5:0]});
               r.cnt     = 3'd4;
            end
         end
      end
      if (lead) begin
         if (b <= 8'h7f) begin
            r.outs[base] = data_res(b);
            r.cnt        = base + 3'd1;
         end else if (b >= 8'hc2 && b <= 8'hdf) begin
            r.nstate = '{needed: 2'd1, cp: {16'd0, b[4:0]}, lower: 8'h80, upper: 8'hbf};
         end else if (b >= 8'he0 && b <= 8'hef) begin
            r.nstate.needed = 2'd2;
            r.nstate.cp     = {17'd0, b[3:0]};
            r.nstate.lower  = (b == 8'he0) ? 8'ha0 : 8'h80;
            r.nstate.upper  = (b == 8'hed) ? 8'h9f : 8'hbf;
         end else if (b >= 8'hf0 && b <= 8'hf4) begin
            r.nstate.needed = 2'd3;
            r.nstate.cp     = {18'd0, b[2:0]};
            r.nstate.lower  = (b == 8'hf0) ? 8'h90 : 8'h80;
            r.nstate.upper  = (b == 8'hf4) ? 8'h8f : 8'hbf;
         end else begin
            r.outs[base]        = data_res(REPL_0);
            r.outs[base + 3'd1] = data_res(REPL_1);
            r.outs[base + 3'd2] = data_res(REPL_2);
            r.cnt               = base + 3'd3;
         end
      end
      byte_expand = r;
   endfunction

   // piece close: truncated sequence gives one replacement, then markers
   function automatic exp_type close_expand(input u8_state_type st, input logic eon,
                                            input logic eop);
      exp_type r;
      r        = '0;
      r.nstate = U8_IDLE;
      if (st.needed != 2'd0) begin
         r.outs[0] = data_res(REPL_0);
         r.outs[1] = data_res(REPL_1);
         r.outs[2] = data_res(REPL_2);
         r.cnt     = 3'd3;
      end
      if (eon) begin
         r.outs[r.cnt] = '{kind: fubd_pkg::KIND_NAME_END, data: 8'h00};
         r.cnt         = r.cnt + 3'd1;
      end
      if (eop) begin
         r.outs[r.cnt] = '{kind: fubd_pkg::KIND_PAIR_END, data: 8'h00};
         r.cnt         = r.cnt + 3'd1;
      end
      close_expand = r;
   endfunction

   u8_state_type      st_ff, st_in;
   logic [1:0]        ei_ff, ei_in;
   logic [2:0]        si_ff, si_in;
   logic              rsp_valid_ff, rsp_valid_in;
   fubd_pkg::res_type rsp_res_ff, rsp_res_in;
   logic              rsp_last_ff, rsp_last_in;

   exp_type    cur;
   exp_type    nxt;
   logic [2:0] nelem;
   logic       out_free;
   logic       go;
   logic       emit;
   logic       elem_done;
   logic       last_elem;
   logic       next_silent;

   assign nelem = {1'b0, head_cmd.nbytes} + {2'b00, head_cmd.close};

   always_comb begin
      if (ei_ff < head_cmd.nbytes) begin
         cur = byte_expand(st_ff, pick_byte(head_cmd.bytes, ei_ff));
      end else begin
         cur = close_expand(st_ff, head_cmd.eon, head_cmd.eop);
      end
      // only a final byte element can give no result, so look one ahead
      nxt = byte_expand(cur.nstate, pick_byte(head_cmd.bytes, ei_ff + 2'd1));
   end

   assign out_free    = !rsp_valid_ff || rsp_if.ready;
   assign go          = head_valid && (cur.cnt == 3'd0 || out_free);
   assign emit        = go && (cur.cnt != 3'd0);
   assign elem_done   = go && (cur.cnt == 3'd0 || si_ff == cur.cnt - 3'd1);
   assign last_elem   = ({1'b0, ei_ff} == nelem - 3'd1);
   assign next_silent = ({1'b0, ei_ff} == nelem - 3'd2) && !head_cmd.close &&
                        (nxt.cnt == 3'd0);
   assign pop         = elem_done && last_elem;

   always_comb begin
      st_in        = st_ff;
      ei_in        = ei_ff;
      si_in        = si_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_if.ready ? 1'b0 : rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = cur.outs[si_ff];
         rsp_last_in  = (si_ff == cur.cnt - 3'd1) && (last_elem || next_silent);
      end
      if (elem_done) begin
         st_in = cur.nstate;
         si_in = 3'd0;
         ei_in = last_elem ? 2'd0 : ei_ff + 2'd1;
      end else if (emit) begin
         si_in = si_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= U8_IDLE;
         ei_ff        <= 2'd0;
         si_ff        <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         ei_ff        <= ei_in;
         si_ff        <= si_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff  <= rsp_res_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.kind     = rsp_res_ff.kind;
   assign rsp_if.out_byte = rsp_res_ff.data;
   assign rsp_if.last     = rsp_last_ff;

endmodule

`default_nettype wire

### sim/fubd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fubd_checker: result predictor and comparator of the form body decoder
// Watches both channels, predicts the decoded results of every accepted
// request transaction and compares each response transaction in order.
// ----------------------------------------------------------------------------

module fubd_checker (
   input  logic clock,
   input  logic reset,
   fubd_req_if  req_if,
   fubd_rsp_if  rsp_if,
   output int   mismatches,
   output int   outstanding
);

   // escape states
   localparam logic [1:0] ESC_NONE    = 2'd0;
   localparam logic [1:0] ESC_PERCENT = 2'd1;
   localparam logic [1:0] ESC_DIGIT   = 2'd2;

   localparam int MAX_PER_BYTE = 8;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } decoded_type;

   decoded_type pending_decoded[$];
   decoded_type byte_results[$];
   int          fail_tally = 0;

   logic        in_value;
   logic        segment_open;
   logic [1:0]  escape_count;
   logic [7:0]  held_digit;
   logic [1:0]  utf8_needed;
   logic [20:0] code_point;
   logic [7:0]  lower_bound;
   logic [7:0]  upper_bound;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
      return 4'd0;
   endfunction

   task automatic put_result(input logic [1:0] k, input logic [7:0] b);
      decoded_type r;
      if (byte_results.size() < MAX_PER_BYTE) begin
         r.kind = k;
         r.data = (k == fubd_pkg::KIND_DATA) ? b : 8'd0;
         r.last = 1'b0;
         byte_results.push_back(r);
      end
   endtask

   task automatic put_replacement();
      put_result(fubd_pkg::KIND_DATA, 8'hef);
      put_result(fubd_pkg::KIND_DATA, 8'hbf);
      put_result(fubd_pkg::KIND_DATA, 8'hbd);
   endtask

   task automatic utf8_clear();
      utf8_needed = 2'd0;
      code_point  = 21'd0;
      lower_bound = 8'h80;
      upper_bound = 8'hbf;
   endtask

   task automatic utf8_take(input logic [7:0] b);
      logic [20:0] cp;
      logic        as_lead;
      as_lead = 1'b1;
      if (utf8_needed != 2'd0) begin
         if (b < lower_bound || b > upper_bound) begin
            // broken sequence: replace it, then treat this byte as a new lead
            put_replacement();
            utf8_clear();
         end else begin
            as_lead     = 1'b0;
            lower_bound = 8'h80;
            upper_bound = 8'hbf;
            code_point  = {code_point[14:0], b[5:0]};
            utf8_needed = utf8_needed - 2'd1;
            if (utf8_needed == 2'd0) begin
               cp = code_point;
               if (cp <= 21'h7f) begin
                  put_result(fubd_pkg::KIND_DATA, cp[7:0]);
               end else if (cp <= 21'h7ff) begin
                  put_result(fubd_pkg::KIND_DATA, {3'b110, cp[10:6]});
                  put_result(fubd_pkg::KIND_DATA, {2'b10, cp[5:0]});
               end else if (cp <= 21'hffff) begin
                  put_result(fubd_pkg::KIND_DATA, {4'b1110, cp[15:12]});
                  put_result(fubd_pkg::KIND_DATA, {2'b10, cp[11:6]});
                  put_result(fubd_pkg::KIND_DATA, {2'b10, cp[5:0]});
               end else begin
                  put_result(fubd_pkg::KIND_DATA, {5'b11110, cp[20:18]});
                  put_result(fubd_pkg::KIND_DATA, {2'b10, cp[17:12]});
                  put_result(fubd_pkg::KIND_DATA, {2'b10, cp[11:6]});
                  put_result(fubd_pkg::KIND_DATA, {2'b10, cp[5:0]});
               end
               code_point = 21'd0;
            end
         end
      end
      if (as_lead) begin
         if (b <= 8'h7f) begin
            put_result(fubd_pkg::KIND_DATA, b);
         end else if (b >= 8'hc2 && b <= 8'hdf) begin
            utf8_needed = 2'd1;
            code_point  = {16'd0, b[4:0]};
         end else if (b >= 8'he0 && b <= 8'hef) begin
            if (b == 8'he0) lower_bound = 8'ha0;
            if (b == 8'hed) upper_bound = 8'h9f;
            utf8_needed = 2'd2;
            code_point  = {17'd0, b[3:0]};
         end else if (b >= 8'hf0 && b <= 8'hf4) begin
            if (b == 8'hf0) lower_bound = 8'h90;
            if (b == 8'hf4) upper_bound = 8'h8f;
            utf8_needed = 2'd3;
            code_point  = {18'd0, b[2:0]};
         end else begin
            put_replacement();
         end
      end
   endtask

   task automatic piece_take(input logic [7:0] b);
      logic done;
      done = 1'b0;
      if (escape_count == ESC_PERCENT) begin
         if (is_hex(b)) begin
            held_digit   = b;
            escape_count = ESC_DIGIT;
            done         = 1'b1;
         end else begin
            utf8_take("%");
            escape_count = ESC_NONE;
         end
      end else if (escape_count == ESC_DIGIT) begin
         if (is_hex(b)) begin
            utf8_take({hex_value(held_digit), hex_value(b)});
            escape_count = ESC_NONE;
            done         = 1'b1;
         end else begin
            utf8_take("%");
            utf8_take(held_digit);
            escape_count = ESC_NONE;
         end
      end
      // malformed escapes fall through and the byte is taken afresh
      if (!done) begin
         if (b == "%") escape_count = ESC_PERCENT;
         else if (b == "+") utf8_take(" ");
         else utf8_take(b);
      end
   endtask

   task automatic piece_flush();
      if (escape_count != ESC_NONE) utf8_take("%");
      if (escape_count == ESC_DIGIT) utf8_take(held_digit);
      escape_count = ESC_NONE;
      if (utf8_needed != 2'd0) put_replacement();
      utf8_clear();
   endtask

   task automatic close_pair();
      piece_flush();
      if (!in_value) put_result(fubd_pkg::KIND_NAME_END, 8'd0);
      put_result(fubd_pkg::KIND_PAIR_END, 8'd0);
      in_value     = 1'b0;
      segment_open = 1'b0;
   endtask

   task automatic decoder_clear();
      in_value     = 1'b0;
      segment_open = 1'b0;
      escape_count = ESC_NONE;
      held_digit   = 8'd0;
      utf8_clear();
   endtask

   task automatic predict_body_byte(input logic [7:0] b, input logic at_end);
      byte_results.delete();
      if (at_end || b == "&") begin
         if (segment_open) close_pair();
      end else begin
         segment_open = 1'b1;
         if (b == "=" && !in_value) begin
            piece_flush();
            put_result(fubd_pkg::KIND_NAME_END, 8'd0);
            in_value = 1'b1;
         end else begin
            piece_take(b);
         end
      end
      if (byte_results.size() != 0) byte_results[byte_results.size() - 1].last = 1'b1;
      foreach (byte_results[i]) pending_decoded.push_back(byte_results[i]);
   endtask

   task automatic compare_result();
      decoded_type want;
      if (pending_decoded.size() == 0) begin
         $error("unexpected result: kind %0d, out_byte 0x%02h, last %0b",
                rsp_if.kind, rsp_if.out_byte, rsp_if.last);
         fail_tally++;
      end else begin
         want = pending_decoded.pop_front();
         if (rsp_if.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, rsp_if.kind);
            fail_tally++;
         end
         if (rsp_if.out_byte !== want.data) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, rsp_if.out_byte);
            fail_tally++;
         end
         if (rsp_if.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, rsp_if.last);
            fail_tally++;
         end
      end
   endtask

   // responses first, so a result can never be matched by its own request edge
   always @(posedge clock) begin
      if (reset) begin
         decoder_clear();
         pending_decoded.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) compare_result();
         if (req_if.valid && req_if.ready) predict_body_byte(req_if.body_byte, req_if.is_end);
      end
      mismatches  <= fail_tally;
      outstanding <= pending_decoded.size();
   end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the form body decoder
// Feeds directed and random urlencoded bodies through the request channel
// under varying idle patterns on both sides; a checker alongside the block
// predicts every result and compares the response stream in order.
// ----------------------------------------------------------------------------

module tb;

   // cycles without any transaction before the run is abandoned
   localparam int STALL_LIMIT  = 2000;
   // settle time after the last expected result
   localparam int DRAIN_CYCLES = 20;

   logic clock;
   logic reset;

   // idle chances in percent, changed per phase
   int send_idle_pct = 13;
   int recv_idle_pct = 80;

   int items_sent   = 0;
   int quiet_cycles = 0;
   int mismatches;
   int outstanding;

   fubd_req_if req_if ();
   fubd_rsp_if rsp_if ();

   form_urlencoded_body_decoder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   fubd_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog: any transaction on either channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request transaction, with a random number of idle cycles first
   // valid stays high after acceptance so back-to-back items need no dip
   task automatic send_item(input logic [7:0] b, input logic at_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.body_byte <= b;
      req_if.is_end    <= at_end;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   // hex letters in either case at random
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return "0" + n;
      return ($urandom_range(1) ? "a" : "A") + n - 8'd10;
   endfunction

   task automatic send_escaped(input logic [7:0] b);
      send_item("%", 1'b0);
      send_item(hex_char(b[7:4]), 1'b0);
      send_item(hex_char(b[3:0]), 1'b0);
   endtask

   // one code point in utf-8, either percent-escaped or as raw bytes
   // the three-byte range includes surrogates, which the decoder must reject
   task automatic send_code_point(input logic escaped);
      logic [20:0] cp;
      logic [7:0]  enc [4];
      int          len;
      len = $urandom_range(4, 1);
      case (len)
         1: begin
            cp     = 21'($urandom_range(21'h7f));
            enc[0] = cp[7:0];
         end
         2: begin
            cp     = 21'($urandom_range(21'h7ff, 21'h80));
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            cp     = 21'($urandom_range(21'hffff, 21'h800));
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            cp     = 21'($urandom_range(21'h10ffff, 21'h10000));
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < len; i++) begin
         if (escaped) send_escaped(enc[i]);
         else send_item(enc[i], 1'b0);
      end
   endtask

   // mostly well-formed pairs with random content, the rest noise
   task automatic random_body(input int count);
      int target;
      int pick;
      target = items_sent + count;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 28) begin
            send_item(8'($urandom_range(8'h7e, 8'h20)), 1'b0);
         end else if (pick < 40) begin
            send_escaped(8'($urandom_range(255)));
         end else if (pick < 55) begin
            send_code_point(1'b1);
         end else if (pick < 63) begin
            send_code_point(1'b0);
         end else if (pick < 70) begin
            send_item("=", 1'b0);
         end else if (pick < 78) begin
            send_item("&", 1'b0);
         end else if (pick < 83) begin
            send_item("+", 1'b0);
         end else if (pick < 89) begin
            // broken escape: '%' with maybe one digit, then anything
            send_item("%", 1'b0);
            if ($urandom_range(1)) send_item(hex_char(4'($urandom_range(15))), 1'b0);
            send_item(8'($urandom_range(255)), 1'b0);
         end else if (pick < 95) begin
            send_item(8'($urandom_range(255)), 1'b0);
         end else begin
            // end of body; the byte beside it must be ignored
            send_item(8'($urandom_range(255)), 1'b1);
         end
      end
   endtask

   initial begin
      req_if.valid     = 1'b0;
      req_if.body_byte = 8'd0;
      req_if.is_end    = 1'b0;
      reset            = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // empty segment at the very start: no results
      send_item("&", 1'b0);
      // lowest byte value as name data
      send_item(8'h00, 1'b0);
      // plus to space, escapes in both cases, a lead and one continuation,
      // then '=' cuts the utf-8 sequence and gives one replacement
      send_text("+%e9%Af=");
      // malformed escape emitted verbatim, second '=' is plain value data
      send_text("%G=");
      // highest byte value: never valid utf-8
      send_item(8'hff, 1'b0);
      // pending lead plus held '%' and digit, then a bad byte: eight results
      send_text("%e2%8");
      send_item(8'hff, 1'b0);
      // escape still pending when the pair closes
      send_text("%7&");
      // segment without '=' closed by the end marker
      send_item("x", 1'b0);
      send_item(8'h00, 1'b1);
      // end marker with nothing open
      send_item(8'hff, 1'b1);

      // --- random part, three idle patterns ---
      random_body(110);
      send_idle_pct = 80;
      recv_idle_pct = 13;
      random_body(110);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_body(115);
      send_item(8'h00, 1'b1);
      req_if.valid <= 1'b0;

      // wait out the remaining results; the watchdog guards a hang here
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
